FILE: src/rwr_pkg.sv
// Package for the ranger wall repulsion block: widths, constants and the CORDIC angle table.
// No dependencies.
package rwr_pkg;

	localparam int RANGE_W = 16;
	localparam int SUM_W   = 48;
	// Working width of the force and CORDIC datapath.
	localparam int WORK_W  = 64;
	localparam int ATAN_ENTRIES = 24;

	localparam logic [2:0] REG_MIN_ANGLE  = 3'd0;
	localparam logic [2:0] REG_ANGLE_STEP = 3'd1;
	localparam logic [2:0] REG_MAX_RANGE  = 3'd2;
	localparam logic [2:0] REG_CHARGE     = 3'd3;
	localparam logic [2:0] REG_NEAR_RANGE = 3'd4;

	localparam logic signed [47:0] NEAR_SCALE = 48'sd2560000;
	localparam logic signed [17:0] GAIN_Q16   = 18'sd39797;
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQUARE, ST_DIV, ST_SIGN, ST_GAIN, ST_ROT, ST_ACC, ST_OUT
	} state_t;

	function automatic logic signed [33:0] atan_turn32(input logic [4:0] i);
		logic signed [33:0] v;
		case (i)
			5'd0:  v = 34'sd536870912;
			5'd1:  v = 34'sd316933406;
			5'd2:  v = 34'sd167458907;
			5'd3:  v = 34'sd85004756;
			5'd4:  v = 34'sd42667331;
			5'd5:  v = 34'sd21354465;
			5'd6:  v = 34'sd10679838;
			5'd7:  v = 34'sd5340245;
			5'd8:  v = 34'sd2670163;
			5'd9:  v = 34'sd1335087;
			5'd10: v = 34'sd667544;
			5'd11: v = 34'sd333772;
			5'd12: v = 34'sd166886;
			5'd13: v = 34'sd83443;
			5'd14: v = 34'sd41722;
			5'd15: v = 34'sd20861;
			5'd16: v = 34'sd10430;
			5'd17: v = 34'sd5215;
			5'd18: v = 34'sd2608;
			5'd19: v = 34'sd1304;
			5'd20: v = 34'sd652;
			5'd21: v = 34'sd326;
			5'd22: v = 34'sd163;
			5'd23: v = 34'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: src/rwr_div.sv
// Restoring divider, one quotient bit per cycle, for the far-field force magnitude.
// Depends on rwr_pkg.
module rwr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [44:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [44:0] quotient
);
	import rwr_pkg::*;

	logic [44:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [33:0] diff;

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q[31:0], quo_q[44]};
		diff  = {1'b0, trial} - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd45;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[43:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[43:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;

endmodule

FILE: src/ranger_wall_repulsion_top.sv
// Ranger wall repulsion: per-reading force, CORDIC resolution and saturating sums.
// Depends on rwr_pkg and rwr_div.
// Each item passes IDLE, SQUARE, then DIV (far readings only), SIGN, GAIN, the CORDIC_STEPS
// steps in ROT, and ACC; an ignored reading goes from SQUARE straight to ACC; one item at a time.
// A last reading adds the OUT state, held while the previous result waits to be taken.
// arst_n clears control state, sums, index and loads register reset values.
module ranger_wall_repulsion_top #(
	parameter int MAX_READINGS = 1024,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // range
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // force_x [47:0], force_y [95:48]
);
	import rwr_pkg::*;

	localparam int IDX_W = $clog2(MAX_READINGS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_READINGS - 1);

	logic [15:0] min_angle_q, angle_step_q, max_range_q, near_range_q;
	logic signed [15:0] charge_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic [IDX_W-1:0] idx_q;
	state_t state_q, state_d;
	logic [15:0] range_q;
	logic last_q;
	logic signed [WORK_W-1:0] f_q, x_q, y_q, z_q;
	logic [15:0] bearing_q;
	logic [31:0] range_sq;
	logic [4:0] step_q;
	logic div_start, div_done;
	logic [44:0] div_quo;
	logic [44:0] div_num;
	logic [15:0] qmag;
	logic out_valid_q;
	logic [95:0] out_data_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_angle_q  <= 16'h8000;
			angle_step_q <= 16'd256;
			max_range_q  <= 16'hFFFF;
			charge_q     <= -16'sd100;
			near_range_q <= 16'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_ANGLE:  min_angle_q  <= cfg_data;
				REG_ANGLE_STEP: angle_step_q <= cfg_data;
				REG_MAX_RANGE:  max_range_q  <= cfg_data;
				REG_CHARGE:     charge_q     <= cfg_data;
				REG_NEAR_RANGE: near_range_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign qmag = charge_q[15] ? 16'(-charge_q) : 16'(charge_q);
	// The divider latches the squared range when it starts.
	assign range_sq = range_q * range_q;
	assign div_num = {1'b0, qmag, 28'd0} + 45'({1'b0, range_sq[31:1]});

	rwr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_num), .divisor(range_sq),
		.done(div_done), .quotient(div_quo)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_SQUARE;
			ST_SQUARE: begin
				if (range_q >= max_range_q) state_d = ST_ACC;
				else if (range_q <= near_range_q) state_d = ST_SIGN;
				else state_d = ST_DIV;
			end
			ST_DIV:  if (div_done) state_d = ST_SIGN;
			ST_SIGN: state_d = ST_GAIN;
			ST_GAIN: state_d = ST_ROT;
			ST_ROT:  if (step_q == 5'(CORDIC_STEPS - 1)) state_d = ST_ACC;
			ST_ACC:  state_d = last_q ? ST_OUT : ST_IDLE;
			ST_OUT:  if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		div_start = (state_q == ST_SQUARE) && (range_q < max_range_q)
			&& (range_q > near_range_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Datapath: a shared shift/add unit over the CORDIC steps.
	logic signed [WORK_W-1:0] xs, ys, zstep;
	logic signed [WORK_W-1:0] gain_prod;
	logic signed [31:0] a_s;
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign zstep = WORK_W'(atan_turn32(step_q));
	assign gain_prod = f_q * WORK_W'(GAIN_Q16) + 64'sd32768;
	assign a_s = {{16{bearing_q[15]}}, bearing_q};

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				range_q   <= s_tdata;
				last_q    <= s_tlast;
				bearing_q <= min_angle_q + 16'(idx_q * angle_step_q);
			end
			ST_SQUARE: begin
				f_q   <= WORK_W'(charge_q) * WORK_W'(NEAR_SCALE);
			end
			ST_DIV: if (div_done)
				f_q <= charge_q[15] ? -WORK_W'(div_quo) : WORK_W'(div_quo);
			ST_SIGN: begin
				if (a_s > 32'sd16384 || a_s < -32'sd16384) begin
					f_q <= -f_q;
					z_q <= WORK_W'(a_s > 0 ? a_s - 32'sd32768 : a_s + 32'sd32768) <<< 16;
				end else begin
					z_q <= WORK_W'(a_s) <<< 16;
				end
			end
			ST_GAIN: begin
				x_q <= gain_prod >>> 16;
				y_q <= '0;
				step_q <= '0;
			end
			ST_ROT: begin
				if (!z_q[WORK_W-1]) begin
					x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - zstep;
				end else begin
					x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + zstep;
				end
				step_q <= step_q + 5'd1;
			end
			default: ;
		endcase
	end

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a, input logic signed [WORK_W-1:0] b);
		logic signed [WORK_W:0] s;
		s = (WORK_W+1)'(a) + (WORK_W+1)'(b);
		if (s > (WORK_W+1)'(SUM_MAX)) return SUM_MAX;
		if (s < (WORK_W+1)'(SUM_MIN)) return SUM_MIN;
		return s[SUM_W-1:0];
	endfunction

	// Sums, index and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0; sum_y_q <= '0; idx_q <= '0; out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) out_valid_q <= 1'b0;
			if (state_q == ST_ACC) begin
				if (range_q < max_range_q) begin
					sum_x_q <= sat_add(sum_x_q, x_q);
					sum_y_q <= sat_add(sum_y_q, y_q);
				end
				if (!last_q && idx_q != IDX_LAST) idx_q <= idx_q + 1'b1;
			end
			if (state_q == ST_OUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
				sum_x_q <= '0; sum_y_q <= '0; idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || m_tready))
			out_data_q <= {sum_y_q, sum_x_q};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: tb/sv/tb.sv
// Testbench for ranger_wall_repulsion_top: drives range readings as scans, predicts the
// summed wall forces and checks every result transfer. Depends on rwr_pkg and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rwr_pkg::*;

	localparam int N_READ = 1024;
	localparam int N_STEPS = 16;
	localparam longint S_MAX = 64'sd140737488355327;
	localparam longint S_MIN = -64'sd140737488355328;

	typedef struct packed {
		logic [15:0] range;
		logic        last;
	} reading_t;

	typedef struct packed {
		logic [47:0] fy;
		logic [47:0] fx;
	} force_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;

	ranger_wall_repulsion_top DUT (.*);

	// Predictor state and register copies.
	logic [15:0] p_min_angle, p_step, p_max, p_near;
	logic signed [15:0] p_charge;
	longint p_sx, p_sy;
	int p_idx;

	reading_t pending_q[$];
	force_t   force_q[$];
	int errors = 0;
	int send_idle = 9;
	int recv_idle = 54;
	int hold_cycles = 0;
	bit in_xfer = 0;

	localparam longint ATAN [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint sat(longint a, longint b);
		longint s;
		s = a + b;
		if (s > S_MAX) return S_MAX;
		if (s < S_MIN) return S_MIN;
		return s;
	endfunction

	// Force from one reading, before resolution.
	function automatic longint wall_force(int r);
		longint q, den, mag;
		q = (p_charge < 0) ? -longint'(p_charge) : longint'(p_charge);
		if (r <= p_near) return longint'(p_charge) * 10000 * 256;
		den = longint'(r) * r;
		mag = ((q << 28) + (den >> 1)) / den;
		return (p_charge < 0) ? -mag : mag;
	endfunction

	// Apply one accepted reading; queue the force sums on the last one.
	task automatic predict_reading(reading_t it);
		int idx, a, i;
		logic [15:0] brg;
		longint f, x, y, z, nx;
		idx = (p_idx > N_READ - 1) ? N_READ - 1 : p_idx;
		if (it.range < p_max) begin
			brg = p_min_angle + 16'(idx * p_step);
			a = $signed(brg);
			f = wall_force(it.range);
			if (a > 16384 || a < -16384) begin
				f = -f;
				a = (a > 0) ? a - 32768 : a + 32768;
			end
			x = fshift(f * 39797 + 32768, 16);
			y = 0;
			z = longint'(a) * 65536;
			for (i = 0; i < N_STEPS; i++) begin
				if (z >= 0) begin
					nx = x - fshift(y, i);
					y = y + fshift(x, i);
					z -= ATAN[i];
				end else begin
					nx = x + fshift(y, i);
					y = y - fshift(x, i);
					z += ATAN[i];
				end
				x = nx;
			end
			p_sx = sat(p_sx, x);
			p_sy = sat(p_sy, y);
		end
		if (it.last) begin
			force_q.push_back('{fy: p_sy[47:0], fx: p_sx[47:0]});
			p_sx = 0;
			p_sy = 0;
			p_idx = 0;
		end else begin
			p_idx = (idx < N_READ - 1) ? idx + 1 : idx;
		end
	endtask

	task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
		$display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
		errors++;
	endtask

	// Register write at the idle block, mirrored into the predictor.
	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MIN_ANGLE:  p_min_angle = v;
			REG_ANGLE_STEP: p_step = v;
			REG_MAX_RANGE:  p_max = v;
			REG_CHARGE:     p_charge = v;
			REG_NEAR_RANGE: p_near = v;
			default: ;
		endcase
	endtask

	// Wait for the block to finish everything offered so far.
	task automatic drain();
		while (pending_q.size() != 0 || force_q.size() != 0 || s_tvalid) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_range();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 20));
			1: return 16'($urandom_range(0, 65535));
			2: return 16'($urandom_range(900, 4000));
			3: return 16'hFFFF;
			default: return 16'($urandom_range(20, 900));
		endcase
	endfunction

	// One scan of n readings, last marked on the final one.
	task automatic add_scan(int n);
		for (int i = 0; i < n; i++)
			pending_q.push_back('{range: rand_range(), last: (i == n - 1)});
	endtask

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Input transfer seen at the rising edge, used by the sender at the next falling edge.
	always @(posedge clk) begin
		in_xfer <= arst_n && s_tvalid && s_tready;
	end

	// Sender: offers the head of the pending queue.
	always @(negedge clk) begin
		if (in_xfer && pending_q.size() != 0) begin
			predict_reading(pending_q.pop_front());
		end
		if (!s_tvalid || in_xfer) begin
			if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_q[0].range;
				s_tlast <= pending_q[0].last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off counted here.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// Monitor: compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (force_q.size() == 0) begin
				$display("unexpected result transfer");
				errors++;
			end else begin
				force_t exp_f;
				exp_f = force_q.pop_front();
				if (m_tdata[47:0] !== exp_f.fx) report_mismatch("force_x", m_tdata[47:0], exp_f.fx);
				if (m_tdata[95:48] !== exp_f.fy)
					report_mismatch("force_y", m_tdata[95:48], exp_f.fy);
			end
		end
	end

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		m_tready = 0;
		p_min_angle = 16'h8000;
		p_step = 256;
		p_max = 65535;
		p_charge = -100;
		p_near = 10;
		p_sx = 0;
		p_sy = 0;
		p_idx = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: field extremes, near and far, ignored last, lone reading.
		pending_q.push_back('{range: 16'd0, last: 1'b0});
		pending_q.push_back('{range: 16'd10, last: 1'b0});
		pending_q.push_back('{range: 16'd11, last: 1'b0});
		pending_q.push_back('{range: 16'd1024, last: 1'b0});
		pending_q.push_back('{range: 16'd65534, last: 1'b0});
		pending_q.push_back('{range: 16'd65535, last: 1'b1});
		pending_q.push_back('{range: 16'd500, last: 1'b1});
		drain();
		// Extreme charges, with near force on every reading.
		write_reg(REG_CHARGE, 16'h7FFF);
		write_reg(REG_NEAR_RANGE, 16'hFFFF);
		write_reg(REG_ANGLE_STEP, 16'd0);
		write_reg(REG_MIN_ANGLE, 16'd0);
		for (int i = 0; i < 8; i++) pending_q.push_back('{range: 16'(i * 9000), last: i == 7});
		drain();
		write_reg(REG_CHARGE, 16'h8000);
		write_reg(REG_MIN_ANGLE, 16'h7FFF);
		for (int i = 0; i < 8; i++) pending_q.push_back('{range: 16'd5, last: i == 7});
		drain();
		// Zero max range ignores everything; bad register index is ignored.
		write_reg(REG_MAX_RANGE, 16'd0);
		write_reg(3'd7, 16'h1234);
		write_reg(3'd5, 16'hFFFF);
		pending_q.push_back('{range: 16'd3, last: 1'b0});
		pending_q.push_back('{range: 16'd0, last: 1'b1});
		drain();

		// Random phases over several register settings.
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(REG_MIN_ANGLE, (ph == 1) ? 16'h8000 : (ph == 2) ? 16'h7FFF :
				16'($urandom_range(0, 65535)));
			write_reg(REG_ANGLE_STEP, (ph == 3) ? 16'hFFFF : (ph == 4) ? 16'd0 :
				16'($urandom_range(0, 65535)));
			write_reg(REG_MAX_RANGE, (ph == 5) ? 16'd0 : (ph % 3 == 0) ? 16'hFFFF :
				16'($urandom_range(1000, 65535)));
			write_reg(REG_CHARGE, (ph == 6) ? 16'h7FFF : (ph == 7) ? 16'h8000 :
				16'($urandom_range(0, 65535)));
			write_reg(REG_NEAR_RANGE, (ph == 8) ? 16'hFFFF : (ph == 9) ? 16'd0 :
				16'($urandom_range(0, 40)));
			if (ph == 4) begin
				send_idle = 54;
				recv_idle = 9;
			end else if (ph == 8) begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (ph == 2) begin
				// Long receiver stall while scans keep coming.
				hold_cycles = 3000;
				for (int k = 0; k < 20; k++) add_scan(2);
			end
			if (ph == 10) add_scan(1100);
			else for (int k = 0; k < 12; k++) add_scan($urandom_range(1, 12));
			drain();
		end

		repeat (100) @(negedge clk);
		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule
